@@ sv/cpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Colour pick table package
// Shared constants, codes and types for the colour pick table core and cells.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ID_WIDTH_DEF    = 16;

	localparam int OPCODE_W = 3;
	localparam int COLOR_W  = 24;
	localparam int FORMAT_W = 8;
	localparam int GROUP_W  = 16;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 8;
	localparam int OBJECT_W = 16;

	localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SETGRP = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CLOSE  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [FORMAT_W-1:0] ACCEPTED_FORMAT = 8'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADFMT   = 2'd3;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_state_t;

	// Write controls broadcast to every cell of the row.
	typedef struct packed {
		logic push;
		logic close;
		logic clear;
	} cpt_ctl_t;

endpackage
`default_nettype wire

@@ sv/cpt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Colour pick table cell
// Holds one table entry and forwards the lookup match word to its neighbour.
// ----------------------------------------------------------------------------
module cpt_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 8,
	parameter int CNT_W = 9,
	parameter int ID_W  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cpt_pkg::cpt_ctl_t        ctl,
	input  wire logic [CNT_W-1:0]         count,
	input  wire logic [cpt_pkg::COLOR_W-1:0] wr_color,
	input  wire logic [ID_W-1:0]          open_id,
	input  wire logic [cpt_pkg::COLOR_W-1:0] key,
	input  wire logic                     hit_in,
	input  wire logic [IDX_W-1:0]         idx_in,
	input  wire logic                     grp_in,
	input  wire logic [ID_W-1:0]          oid_in,
	output logic                          hit_out,
	output logic [IDX_W-1:0]              idx_out,
	output logic                          grp_out,
	output logic [ID_W-1:0]               oid_out
);
	import cpt_pkg::*;

	logic [COLOR_W-1:0] color_q;
	logic [ID_W-1:0]    group_q;
	logic               pending_q;
	logic               grouped_q;
	logic               push_here;
	logic               match;

	assign push_here = ctl.push && (count == CNT_W'(INDEX));
	assign match     = (pending_q || grouped_q) && (color_q == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			grouped_q <= 1'b0;
		end else if (ctl.clear) begin
			pending_q <= 1'b0;
			grouped_q <= 1'b0;
		end else if (push_here) begin
			pending_q <= 1'b1;
			grouped_q <= 1'b0;
		end else if (ctl.close && pending_q) begin
			pending_q <= 1'b0;
			grouped_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_here) begin
			color_q <= wr_color;
		end
		if (ctl.close && pending_q) begin
			group_q <= open_id;
		end
	end

	// A hit from an earlier cell has priority, so the lowest index wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_out <= 1'b0;
		end else begin
			hit_out <= hit_in || match;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_in) begin
			idx_out <= idx_in;
			grp_out <= grp_in;
			oid_out <= oid_in;
		end else begin
			idx_out <= IDX_W'(INDEX);
			grp_out <= grouped_q;
			oid_out <= grouped_q ? group_q : '0;
		end
	end

endmodule
`default_nettype wire

@@ sv/color_pick_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Colour pick table core
// Maps rendered colours back to table indices and group object ids.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Word
//  command   start / busy           opcode, color, pixel_format, group_id
//  result    done (one cycle)       status, color_found, entry_index,
//                                   group_found, object_id
//
//  Push, set group, close, clear, spare opcodes and rejected lookups finish
//  without a scan. A lookup walks the match word along the row of cells one
//  cell per cycle. Reset leaves the table empty and the open group id at
//  zero. The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module color_pick_table_core #(
	parameter int TABLE_DEPTH = cpt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_WIDTH    = cpt_pkg::ID_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [cpt_pkg::OPCODE_W-1:0] opcode,
	input  wire logic [cpt_pkg::COLOR_W-1:0]  color,
	input  wire logic [cpt_pkg::FORMAT_W-1:0] pixel_format,
	input  wire logic [cpt_pkg::GROUP_W-1:0]  group_id,
	output logic                              done,
	output logic [cpt_pkg::STATUS_W-1:0]      status,
	output logic                              color_found,
	output logic [cpt_pkg::INDEX_W-1:0]       entry_index,
	output logic                              group_found,
	output logic [cpt_pkg::OBJECT_W-1:0]      object_id
);
	import cpt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam int OW    = (ID_WIDTH > OBJECT_W) ? ID_WIDTH : OBJECT_W;

	fsm_state_t         state_q, state_d;
	cpt_ctl_t           ctl;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [ID_WIDTH-1:0] open_id_q;
	logic [COLOR_W-1:0] key_q;
	logic               accept;
	logic               key_load;
	logic               setgrp;
	logic               res_load;

	logic [STATUS_W-1:0] res_status;
	logic                res_cfound;
	logic [INDEX_W-1:0]  res_index;
	logic                res_gfound;
	logic [OBJECT_W-1:0] res_oid;

	logic [IW-1:0]      count_wide;
	logic [IW-1:0]      tail_idx_wide;
	logic [OW-1:0]      tail_oid_wide;
	logic [OW-1:0]      gid_wide;

	logic                hit_w [0:TABLE_DEPTH];
	logic [IDX_W-1:0]    idx_w [0:TABLE_DEPTH];
	logic                grp_w [0:TABLE_DEPTH];
	logic [ID_WIDTH-1:0] oid_w [0:TABLE_DEPTH];

	assign busy          = (state_q == FSM_SCAN);
	assign accept        = start && !busy;
	assign count_wide    = IW'(count_q);
	assign tail_idx_wide = IW'(idx_w[TABLE_DEPTH]);
	assign tail_oid_wide = OW'(oid_w[TABLE_DEPTH]);
	assign gid_wide      = OW'(group_id);

	assign hit_w[0] = 1'b0;
	assign idx_w[0] = '0;
	assign grp_w[0] = 1'b0;
	assign oid_w[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cpt_cell #(
			.INDEX (i),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W),
			.ID_W  (ID_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.count    (count_q),
			.wr_color (color),
			.open_id  (open_id_q),
			.key      (key_q),
			.hit_in   (hit_w[i]),
			.idx_in   (idx_w[i]),
			.grp_in   (grp_w[i]),
			.oid_in   (oid_w[i]),
			.hit_out  (hit_w[i+1]),
			.idx_out  (idx_w[i+1]),
			.grp_out  (grp_w[i+1]),
			.oid_out  (oid_w[i+1])
		);
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		key_load   = 1'b0;
		setgrp     = 1'b0;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_cfound = 1'b0;
		res_index  = '0;
		res_gfound = 1'b0;
		res_oid    = '0;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					res_load = 1'b1;
					unique case (opcode)
						OP_PUSH: begin
							if (count_q == CNT_W'(TABLE_DEPTH)) begin
								res_status = ST_FULL;
							end else begin
								ctl.push  = 1'b1;
								res_index = count_wide[INDEX_W-1:0];
							end
						end
						OP_SETGRP: begin
							setgrp = 1'b1;
						end
						OP_CLOSE: begin
							ctl.close = 1'b1;
						end
						OP_LOOKUP: begin
							if (pixel_format != ACCEPTED_FORMAT) begin
								res_status = ST_BADFMT;
							end else begin
								res_load = 1'b0;
								key_load = 1'b1;
								state_d  = FSM_SCAN;
							end
						end
						OP_CLEAR: begin
							ctl.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			FSM_SCAN: begin
				if (scan_q == CNT_W'(TABLE_DEPTH)) begin
					res_load = 1'b1;
					state_d  = FSM_IDLE;
					if (hit_w[TABLE_DEPTH]) begin
						res_cfound = 1'b1;
						res_index  = tail_idx_wide[INDEX_W-1:0];
						res_gfound = grp_w[TABLE_DEPTH];
						res_oid    = tail_oid_wide[OBJECT_W-1:0];
					end else begin
						res_status = ST_NOTFOUND;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			open_id_q <= '0;
			done      <= 1'b0;
		end else begin
			done <= res_load;
			if (ctl.clear) begin
				count_q <= '0;
			end else if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end
			if (key_load) begin
				scan_q <= '0;
			end else if (busy) begin
				scan_q <= scan_q + 1'b1;
			end
			if (setgrp) begin
				open_id_q <= gid_wide[ID_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_load) begin
			key_q <= color;
		end
		if (res_load) begin
			status      <= res_status;
			color_found <= res_cfound;
			entry_index <= res_index;
			group_found <= res_gfound;
			object_id   <= res_oid;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("Entry count has passed the table depth.");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_LOOKUP && pixel_format == ACCEPTED_FORMAT |=> busy && !done)
		else $error("A valid lookup did not start a scan.");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> count_q == CNT_W'(TABLE_DEPTH))
		else $error("A push was refused while the table had room.");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy && scan_q == CNT_W'(TABLE_DEPTH) |=> !busy && done)
		else $error("A scan ran past the end of the row without a result.");

endmodule
`default_nettype wire

@@ bench/color_pick_table_core_test.sv @@
// ----------------------------------------------------------------------------
// Colour pick table core regression
// Drives command words through the start/busy port and compares every result
// word with a behavioural table kept alongside or a pinned word. A short
// table of commands comes first: it covers the empty table, format rejection,
// spare opcodes, lowest-index matching and grouping. Random commands then fill
// the table until pushes are refused, clear it again and look colours up
// throughout. The sender idles at three different rates.
// ----------------------------------------------------------------------------
module color_pick_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int RANDOM_WORDS = 1600;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int ROW_COUNT    = 27;
	localparam int PRINT_LIMIT  = 40;

	localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                color_found;
		logic [INDEX_W-1:0]  entry_index;
		logic                group_found;
		logic [OBJECT_W-1:0] object_id;
	} pick_result_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [COLOR_W-1:0]  col;
		logic [FORMAT_W-1:0] fmt;
		logic [GROUP_W-1:0]  gid;
		logic                pinned;
		pick_result_t        want;
	} pick_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [COLOR_W-1:0]  color = '0;
	logic [FORMAT_W-1:0] pixel_format = '0;
	logic [GROUP_W-1:0]  group_id = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic                color_found;
	logic [INDEX_W-1:0]  entry_index;
	logic                group_found;
	logic [OBJECT_W-1:0] object_id;

	// Shadow copy of the pick table.
	logic [COLOR_W-1:0]  tbl_color [DEPTH];
	logic [OBJECT_W-1:0] tbl_group [DEPTH];
	bit                  tbl_grouped [DEPTH];
	bit                  tbl_pending [DEPTH];
	int                  tbl_count = 0;
	logic [OBJECT_W-1:0] tbl_open_id = '0;

	pick_result_t        awaited_results [$];
	logic [COLOR_W-1:0]  palette [16];
	bit                  row_pinned = 1'b0;
	pick_result_t        row_want = '0;
	int                  send_idle_pct = 27;
	int                  fail_count = 0;
	int                  cycle_count = 0;

	pick_row_t directed_rows [ROW_COUNT] = '{
		'{OP_LOOKUP, 24'h000000, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_NOTFOUND, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_BADFMT, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1,
			'{ST_BADFMT, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_CLOSE, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_RSVD5, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_RSVD6, 24'hFFFFFF, ACCEPTED_FORMAT, 16'hFFFF, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_RSVD7, 24'hFFFFFF, ACCEPTED_FORMAT, 16'hFFFF, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_PUSH, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_PUSH, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1,
			'{ST_OK, 1'b0, 8'd1, 1'b0, 16'h0000}},
		'{OP_PUSH, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd2, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'hFFFFFF, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_OK, 1'b1, 8'd1, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h000000, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_OK, 1'b1, 8'd0, 1'b0, 16'h0000}},
		'{OP_SETGRP, 24'h000000, 8'h00, 16'hFFFF, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_CLOSE, 24'hFFFFFF, 8'hFF, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h000000, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_OK, 1'b1, 8'd0, 1'b1, 16'hFFFF}},
		'{OP_SETGRP, 24'hFFFFFF, 8'hFF, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_PUSH, 24'h123456, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd3, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h123456, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_OK, 1'b1, 8'd3, 1'b0, 16'h0000}},
		'{OP_CLOSE, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h123456, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_OK, 1'b1, 8'd3, 1'b1, 16'h0000}},
		'{OP_LOOKUP, 24'hFFFFFF, 8'h02, 16'h0000, 1'b1,
			'{ST_BADFMT, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'hABCDEF, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_NOTFOUND, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_CLEAR, 24'h000000, 8'h00, 16'h0000, 1'b1,
			'{ST_OK, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_LOOKUP, 24'h000000, ACCEPTED_FORMAT, 16'h0000, 1'b1,
			'{ST_NOTFOUND, 1'b0, 8'd0, 1'b0, 16'h0000}},
		'{OP_PUSH, 24'hFF00FF, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_CLOSE, 24'h000000, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_LOOKUP, 24'hFF00FF, ACCEPTED_FORMAT, 16'h0000, 1'b0, '0}
	};

	color_pick_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.color        (color),
		.pixel_format (pixel_format),
		.group_id     (group_id),
		.done         (done),
		.status       (status),
		.color_found  (color_found),
		.entry_index  (entry_index),
		.group_found  (group_found),
		.object_id    (object_id)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	// Applies one command word to the shadow table and gives its result word.
	task automatic pick_table_apply(input logic [OPCODE_W-1:0] op,
			input logic [COLOR_W-1:0] col, input logic [FORMAT_W-1:0] fmt,
			input logic [GROUP_W-1:0] gid, output pick_result_t res);
		bit hit;
		hit = 1'b0;
		res = '0;
		case (op)
			OP_PUSH: begin
				if (tbl_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					res.entry_index = INDEX_W'(tbl_count);
					tbl_color[tbl_count] = col;
					tbl_pending[tbl_count] = 1'b1;
					tbl_grouped[tbl_count] = 1'b0;
					tbl_count++;
				end
			end
			OP_SETGRP: begin
				tbl_open_id = gid;
			end
			OP_CLOSE: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (tbl_pending[i]) begin
						tbl_pending[i] = 1'b0;
						tbl_grouped[i] = 1'b1;
						tbl_group[i] = tbl_open_id;
					end
				end
			end
			OP_LOOKUP: begin
				if (fmt != ACCEPTED_FORMAT) begin
					res.status = ST_BADFMT;
				end else begin
					for (int i = 0; i < tbl_count; i++) begin
						if (!hit && tbl_color[i] == col) begin
							hit = 1'b1;
							res.color_found = 1'b1;
							res.entry_index = INDEX_W'(i);
							if (tbl_grouped[i]) begin
								res.group_found = 1'b1;
								res.object_id = tbl_group[i];
							end
						end
					end
					if (!hit) begin
						res.status = ST_NOTFOUND;
					end
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					tbl_grouped[i] = 1'b0;
					tbl_pending[i] = 1'b0;
				end
				tbl_count = 0;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		pick_result_t want;
		pick_result_t got;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result word with no command outstanding");
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("color_found", 32'(color_found),
						32'(want.color_found));
					check_field("entry_index", 32'(entry_index),
						32'(want.entry_index));
					check_field("group_found", 32'(group_found),
						32'(want.group_found));
					check_field("object_id", 32'(object_id), 32'(want.object_id));
				end
			end
			if (start && !busy) begin
				pick_table_apply(opcode, color, pixel_format, group_id, got);
				awaited_results.push_back(row_pinned ? row_want : got);
			end
		end
	end

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_word(input logic [OPCODE_W-1:0] op,
			input logic [COLOR_W-1:0] col, input logic [FORMAT_W-1:0] fmt,
			input logic [GROUP_W-1:0] gid, input bit pinned,
			input pick_result_t want);
		int gap;
		start <= 1'b1;
		opcode <= op;
		color <= col;
		pixel_format <= fmt;
		group_id <= gid;
		row_pinned = pinned;
		row_want = want;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300) :
				$urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("color_pick_table_core regression: fail");
		$finish;
	end

	initial begin
		logic [OPCODE_W-1:0] op;
		logic [COLOR_W-1:0]  col;
		logic [FORMAT_W-1:0] fmt;
		logic [GROUP_W-1:0]  gid;
		int                  r;
		int                  idle_plan [3];
		idle_plan = '{27, 83, 0};
		for (int i = 0; i < 16; i++) begin
			palette[i] = COLOR_W'($urandom());
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k]) begin
			send_word(directed_rows[k].op, directed_rows[k].col, directed_rows[k].fmt,
				directed_rows[k].gid, directed_rows[k].pinned, directed_rows[k].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = idle_plan[phase];
			for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
				r = $urandom_range(0, 99);
				col = COLOR_W'($urandom());
				fmt = FORMAT_W'($urandom());
				gid = GROUP_W'($urandom());
				if (r < 45) begin
					op = OP_PUSH;
					if ($urandom_range(0, 2) != 0) begin
						col = palette[$urandom_range(0, 15)];
					end
				end else if (r < 55) begin
					op = OP_SETGRP;
				end else if (r < 65) begin
					op = OP_CLOSE;
				end else if (r < 97) begin
					op = OP_LOOKUP;
					if ($urandom_range(0, 9) != 0) begin
						fmt = ACCEPTED_FORMAT;
					end
					if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
						col = tbl_color[$urandom_range(0, tbl_count - 1)];
					end else if ($urandom_range(0, 1) == 0) begin
						col = palette[$urandom_range(0, 15)];
					end
				end else if (r < 99) begin
					op = OPCODE_W'($urandom_range(OP_RSVD5, OP_RSVD7));
				end else begin
					op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_CLOSE;
				end
				// Once full, stay there a while so refused pushes are seen.
				if (tbl_count >= DEPTH && $urandom_range(0, 14) == 0) begin
					op = OP_CLEAR;
				end
				send_word(op, col, fmt, gid, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("color_pick_table_core regression: pass");
		end else begin
			$display("color_pick_table_core regression: fail");
		end
		$finish;
	end

endmodule
